### src/rope_pkg.sv
// Package for the rotary position embedding block: sizes, register indexes,
// payload structs and the command format passed from front end to back end.
// No dependencies.
package rope_pkg;

  localparam int MAX_HALF  = 64;
  localparam int MAX_HEADS = 64;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [6:0]  HALF_RESET = 7'd64;
  localparam logic [6:0]  HEADS_RESET = 7'd32;
  localparam logic [15:0] SEQ_RESET  = 16'd2048;

  // Configuration register indexes
  localparam logic [1:0] REG_HALF_DIM   = 2'd0;
  localparam logic [1:0] REG_NUM_HEADS  = 2'd1;
  localparam logic [1:0] REG_SEQ_LENGTH = 2'd2;

  // Input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         angle_index;
    logic signed [15:0] angle_cos;
    logic signed [15:0] angle_sin;
    logic signed [15:0] element_value;
  } rope_in_t;

  typedef struct packed {
    logic [5:0]         pair_index;
    logic signed [15:0] rotated_low;
    logic signed [15:0] rotated_high;
    logic               is_key;
    logic [5:0]         head_number;
    logic               end_of_vector;
    logic               end_of_position;
    logic               end_of_sequence;
    logic               saturated;
  } rope_out_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_STORE,
    KIND_ROTATE
  } rope_kind_t;

  typedef struct packed {
    logic       is_key;
    logic [5:0] head_number;
    logic       eov;
    logic       eop;
    logic       eos;
  } rope_tag_t;

  typedef struct packed {
    rope_kind_t         kind;
    logic [5:0]         addr;
    logic signed [15:0] val_a;
    logic signed [15:0] val_b;
    rope_tag_t          tag;
  } rope_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rope_qstat_t;

endpackage

### src/rope_front.sv
// Front end of the rotary position embedding block: configuration registers,
// stream counters and classification of input beats into commands.
// Depends on rope_pkg.
module rope_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rope_pkg::rope_in_t in_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  rope_pkg::rope_qstat_t q_stat,
  output logic               push,
  output rope_pkg::rope_cmd_t push_cmd,
  output logic [6:0]         half_eff
);

  logic [6:0]  half_r, half_nxt;
  logic [6:0]  heads_r, heads_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [6:0]  elem_r, elem_nxt;
  logic        key_r, key_nxt;
  logic [5:0]  head_r, head_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic        accept;
  logic [6:0]  j7;
  logic        eov, eop, eos;
  logic        restart;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign half_eff = half_r;

  assign j7  = elem_r - half_r;
  assign eov = (j7 + 7'd1) == half_r;
  assign eop = eov && key_r && (({1'b0, head_r} + 7'd1) >= heads_r);
  assign eos = eop && (({1'b0, pos_r} + 17'd1) >= {1'b0, seq_r});

  always_comb begin
    half_nxt  = half_r;
    heads_nxt = heads_r;
    seq_nxt   = seq_r;
    restart   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        rope_pkg::REG_HALF_DIM: begin
          restart = 1'b1;
          if (cfg_data[6:0] == 7'd0) begin
            half_nxt = 7'd1;
          end else if (cfg_data[6:0] > 7'(rope_pkg::MAX_HALF)) begin
            half_nxt = 7'(rope_pkg::MAX_HALF);
          end else begin
            half_nxt = cfg_data[6:0];
          end
        end
        rope_pkg::REG_NUM_HEADS: begin
          restart = 1'b1;
          if (cfg_data[6:0] == 7'd0) begin
            heads_nxt = 7'd1;
          end else if (cfg_data[6:0] > 7'(rope_pkg::MAX_HEADS)) begin
            heads_nxt = 7'(rope_pkg::MAX_HEADS);
          end else begin
            heads_nxt = cfg_data[6:0];
          end
        end
        rope_pkg::REG_SEQ_LENGTH: begin
          restart = 1'b1;
          seq_nxt = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    elem_nxt = elem_r;
    key_nxt  = key_r;
    head_nxt = head_r;
    pos_nxt  = pos_r;
    push     = 1'b0;
    push_cmd.kind  = rope_pkg::KIND_LOAD;
    push_cmd.addr  = in_item.angle_index;
    push_cmd.val_a = in_item.angle_cos;
    push_cmd.val_b = in_item.angle_sin;
    push_cmd.tag.is_key      = key_r;
    push_cmd.tag.head_number = head_r;
    push_cmd.tag.eov         = eov;
    push_cmd.tag.eop         = eop;
    push_cmd.tag.eos         = eos;
    if (accept) begin
      if (in_item.operation == rope_pkg::OP_LOAD) begin
        // drop loads beyond the active half
        push = {1'b0, in_item.angle_index} < half_r;
      end else begin
        push = 1'b1;
        push_cmd.val_a = in_item.element_value;
        if (elem_r < half_r) begin
          push_cmd.kind = rope_pkg::KIND_STORE;
          push_cmd.addr = elem_r[5:0];
          elem_nxt      = elem_r + 7'd1;
        end else begin
          push_cmd.kind = rope_pkg::KIND_ROTATE;
          push_cmd.addr = j7[5:0];
          if (!eov) begin
            elem_nxt = elem_r + 7'd1;
          end else begin
            elem_nxt = 7'd0;
            if (!key_r) begin
              key_nxt = 1'b1;
            end else begin
              key_nxt = 1'b0;
              if (!eop) begin
                head_nxt = head_r + 6'd1;
              end else begin
                head_nxt = 6'd0;
                pos_nxt  = eos ? 16'd0 : pos_r + 16'd1;
              end
            end
          end
        end
      end
    end
    if (restart) begin
      elem_nxt = 7'd0;
      key_nxt  = 1'b0;
      head_nxt = 6'd0;
      pos_nxt  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r  <= rope_pkg::HALF_RESET;
      heads_r <= rope_pkg::HEADS_RESET;
      seq_r   <= rope_pkg::SEQ_RESET;
      elem_r  <= 7'd0;
      key_r   <= 1'b0;
      head_r  <= 6'd0;
      pos_r   <= 16'd0;
    end else begin
      half_r  <= half_nxt;
      heads_r <= heads_nxt;
      seq_r   <= seq_nxt;
      elem_r  <= elem_nxt;
      key_r   <= key_nxt;
      head_r  <= head_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

### src/rope_queue.sv
// Short command queue between the front and back ends of the rotary
// position embedding block. Depends on rope_pkg.
module rope_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rope_pkg::rope_cmd_t   push_cmd,
  input  logic                  pop,
  output rope_pkg::rope_cmd_t   head_cmd,
  output rope_pkg::rope_qstat_t q_stat
);

  rope_pkg::rope_cmd_t             slot_r [rope_pkg::QDEPTH];
  logic [rope_pkg::QPTR_W-1:0]     wptr_r, wptr_nxt;
  logic [rope_pkg::QPTR_W-1:0]     rptr_r, rptr_nxt;
  logic [rope_pkg::QPTR_W:0]       count_r, count_nxt;
  logic                            do_pop;

  assign q_stat.empty = count_r == '0;
  assign q_stat.full  = count_r == (rope_pkg::QPTR_W + 1)'(rope_pkg::QDEPTH);
  assign head_cmd     = slot_r[rptr_r];
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### src/rope_back.sv
// Back end of the rotary position embedding block: angle and first-half
// memories, rotation multiplies, rounding, saturation and the output register.
// Depends on rope_pkg.
module rope_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rope_pkg::rope_cmd_t q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rope_pkg::rope_out_t out_item
);

  logic signed [15:0] cos_mem [rope_pkg::MAX_HALF];
  logic signed [15:0] sin_mem [rope_pkg::MAX_HALF];
  logic signed [15:0] fhs_mem [rope_pkg::MAX_HALF];

  logic               adv;
  logic               s1_valid_r, s2_valid_r, out_valid_r;
  logic signed [15:0] c_r, s_r, x0_r, x1_r;
  logic [5:0]         j1_r, j2_r;
  rope_pkg::rope_tag_t tag1_r, tag2_r;
  logic signed [31:0] p_x0c_r, p_x1s_r, p_x0s_r, p_x1c_r;
  logic signed [33:0] lo_sum, hi_sum;
  logic signed [15:0] lo_q, hi_q;
  logic               lo_clip, hi_clip;
  rope_pkg::rope_out_t out_r;

  function automatic logic [16:0] round_sat(input logic signed [33:0] acc);
    logic signed [33:0] rnd;
    logic signed [33:0] q;
    logic [16:0]        res;
    begin
      rnd = acc + 34'sd8192;
      q   = rnd >>> 14;
      if (q > 34'sd32767) begin
        res = {1'b1, 16'h7FFF};
      end else if (q < -34'sd32768) begin
        res = {1'b1, 16'h8000};
      end else begin
        res = {1'b0, q[15:0]};
      end
      return res;
    end
  endfunction

  // Whole pipeline advances unless the output holds a beat that is not taken
  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && q_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Memory stage: write loads and first-half elements, read for rotations
  always_ff @(posedge clk) begin
    if (pop && q_cmd.kind == rope_pkg::KIND_LOAD) begin
      cos_mem[q_cmd.addr] <= q_cmd.val_a;
      sin_mem[q_cmd.addr] <= q_cmd.val_b;
    end
    if (pop && q_cmd.kind == rope_pkg::KIND_STORE) begin
      fhs_mem[q_cmd.addr] <= q_cmd.val_a;
    end
    if (adv) begin
      c_r    <= cos_mem[q_cmd.addr];
      s_r    <= sin_mem[q_cmd.addr];
      x0_r   <= fhs_mem[q_cmd.addr];
      x1_r   <= q_cmd.val_a;
      j1_r   <= q_cmd.addr;
      tag1_r <= q_cmd.tag;
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      p_x0c_r <= x0_r * c_r;
      p_x1s_r <= x1_r * s_r;
      p_x0s_r <= x0_r * s_r;
      p_x1c_r <= x1_r * c_r;
      j2_r    <= j1_r;
      tag2_r  <= tag1_r;
    end
  end

  // Sum, round and saturate into the output register
  assign lo_sum = 34'(p_x0c_r) - 34'(p_x1s_r);
  assign hi_sum = 34'(p_x0s_r) + 34'(p_x1c_r);
  assign {lo_clip, lo_q} = round_sat(lo_sum);
  assign {hi_clip, hi_q} = round_sat(hi_sum);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.pair_index      <= j2_r;
      out_r.rotated_low     <= lo_q;
      out_r.rotated_high    <= hi_q;
      out_r.is_key          <= tag2_r.is_key;
      out_r.head_number     <= tag2_r.head_number;
      out_r.end_of_vector   <= tag2_r.eov;
      out_r.end_of_position <= tag2_r.eop;
      out_r.end_of_sequence <= tag2_r.eos;
      out_r.saturated       <= lo_clip || hi_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop && q_cmd.kind == rope_pkg::KIND_ROTATE;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

endmodule

### src/rotary_position_embedding.sv
// Top level of the rotary position embedding block (half-split form).
// Depends on rope_pkg, rope_front, rope_queue and rope_back.

// Rotary position embedding for a stream of query and key head vectors.
// Load beats (operation 0) write one cosine/sine pair (Q1.14) of the current
// position's angle row; loads at or above half_dim are dropped. Data beats
// (operation 1) carry Q7.8 elements in the order query head 0, key head 0,
// query head 1, ... for each position. First-half elements are buffered; each
// second-half element j+half produces one result beat with
// low = x0*c - x1*s and high = x0*s + x1*c, rounded half up to Q7.8 and
// saturated, with the saturated flag set on clipping. A write to any of the
// three configuration registers restarts the element, head, query/key and
// position counters; the angle and element stores keep their contents.
// Throughput is one beat per cycle, in and out, while the output is not
// stalled: the front end classifies a beat in the cycle it is accepted, and
// the back end pipeline (memory read, multiply, round and saturate) takes one
// command per cycle. On its way to a result, an accepted beat lands in a
// queue slot at the accepting edge, then passes the registered memory read,
// the multiply register and the output register. A stalled output holds the
// back end; the four-entry queue keeps the input side accepting until it
// fills.
module rotary_position_embedding (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rope_pkg::rope_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rope_pkg::rope_out_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                  push;
  rope_pkg::rope_cmd_t   push_cmd;
  rope_pkg::rope_cmd_t   head_cmd;
  rope_pkg::rope_qstat_t q_stat;
  logic                  pop;
  logic [6:0]            half_eff;

  // Accept and classify beats, keep the stream counters
  rope_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd),
    .half_eff (half_eff)
  );

  // Hold commands while the back end stalls
  rope_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // Store, rotate and deliver
  rope_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!q_stat.empty),
    .q_cmd    (head_cmd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

`ifndef SYNTH
  // End of position only on the last pair of a key vector
  a_eop_on_key_eov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_position |->
      out_item.end_of_vector && out_item.is_key)
    else $error("end_of_position without end of key vector");

  // End of sequence only on an end of position
  a_eos_on_eop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_sequence |-> out_item.end_of_position)
    else $error("end_of_sequence without end_of_position");

  // End of vector marks exactly the last pair of the active half
  a_eov_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_item.end_of_vector == ({1'b0, out_item.pair_index} + 7'd1 == half_eff)))
    else $error("end_of_vector does not match pair index");
`endif

endmodule
